/* rtl/quaternion_normalizer_assert.svh */
// ----------------------------------------------------------------------------
// Quaternion normalizer assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_NORMALIZER_ASSERT_SVH
`define QUATERNION_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QN_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qn_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion normalizer package
// Fixed constants shared by the normalizer modules.
// ----------------------------------------------------------------------------
package qn_pkg;

    localparam int NUM_COMP = 4;
    localparam int OUT_BITS = 32;

    typedef logic [OUT_BITS-1:0] t_out;

endpackage

/* rtl/qn_front.sv */
// ----------------------------------------------------------------------------
// Quaternion normalizer front end
// Two stages: magnitudes and squares, then the sum of squares and the
// starting remainder of every component's rounding search.
// ----------------------------------------------------------------------------
module qn_front #(
    parameter int C = 32,
    parameter int F = 30,
    parameter int W = 2 * C + 2 * F + 6
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [qn_pkg::NUM_COMP-1:0][C-1:0]  i_comp,
    output logic [qn_pkg::NUM_COMP-1:0][W-1:0]  o_d,
    output logic [W-1:0]                        o_s,
    output logic [qn_pkg::NUM_COMP-1:0]         o_neg,
    output logic                                o_zero
);
    import qn_pkg::*;

    logic [NUM_COMP-1:0][2*C-1:0] r_sq;
    logic [NUM_COMP-1:0][2*C-1:0] n_sq;
    logic [NUM_COMP-1:0]          r_neg0;
    logic [NUM_COMP-1:0]          n_neg0;
    logic [NUM_COMP-1:0][W-1:0]   r_d;
    logic [NUM_COMP-1:0][W-1:0]   n_d;
    logic [W-1:0]                 r_s;
    logic [W-1:0]                 n_s;
    logic [NUM_COMP-1:0]          r_neg1;
    logic                         r_zero;

    always_comb begin
        logic [C-1:0] mag;
        for (int i = 0; i < NUM_COMP; i++) begin
            n_neg0[i] = i_comp[i][C-1];
            mag       = n_neg0[i] ? (~i_comp[i] + 1'b1) : i_comp[i];
            n_sq[i]   = {{C{1'b0}}, mag} * {{C{1'b0}}, mag};
        end
    end

    always_comb begin
        n_s = '0;
        for (int i = 0; i < NUM_COMP; i++) begin
            n_s = n_s + W'(r_sq[i]);
        end
        for (int i = 0; i < NUM_COMP; i++) begin
            n_d[i] = (W'(r_sq[i]) << (2 * F + 2)) - n_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq   <= n_sq;
            r_neg0 <= n_neg0;
            r_d    <= n_d;
            r_s    <= n_s;
            r_neg1 <= r_neg0;
            r_zero <= (n_s == '0);
        end
    end

    assign o_d    = r_d;
    assign o_s    = r_s;
    assign o_neg  = r_neg1;
    assign o_zero = r_zero;

endmodule

/* rtl/qn_bit.sv */
// ----------------------------------------------------------------------------
// Quaternion normalizer bit stage
// Decides one bit of a rounded scaled ratio by a restoring step on the
// remainder of the squared comparison.
// ----------------------------------------------------------------------------
module qn_bit #(
    parameter int F = 30,
    parameter int W = 130,
    parameter int B = 0
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_s,
    input  logic [W-1:0] i_d,
    input  logic [W-1:0] i_p,
    input  logic [F:0]   i_q,
    output logic [W-1:0] o_d,
    output logic [W-1:0] o_p,
    output logic [F:0]   o_q
);
    import qn_pkg::*;

    logic signed [W-1:0] t;
    logic signed [W-1:0] diff;
    logic [W-1:0]        r_d;
    logic [W-1:0]        r_p;
    logic [F:0]          r_q;

    always_comb begin
        t    = ($signed(i_p) <<< (B + 2)) + $signed(i_s << (2 * B + 2));
        diff = $signed(i_d) - t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!diff[W-1]) begin
                r_d <= diff;
                r_p <= i_p + (i_s << (B + 1));
                r_q <= i_q | ((F+1)'(1) << B);
            end else begin
                r_d <= i_d;
                r_p <= i_p;
                r_q <= i_q;
            end
        end
    end

    assign o_d = r_d;
    assign o_p = r_p;
    assign o_q = r_q;

endmodule

/* rtl/quaternion_normalizer.sv */
// ----------------------------------------------------------------------------
// Quaternion normalizer
// Scales a four-component quaternion to unit length in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
// One request carries the components i_w, i_x, i_y and i_z. It is taken at a
// clock edge where i_valid is high and o_stall is low. The result o_w, o_x,
// o_y, o_z and o_zero_norm is taken where o_valid is high and i_stall is low.
// Each output is the component times 2^OUT_FRAC_BITS over the root of the sum
// of squares, rounded to nearest with ties away from zero. An all-zero input
// gives zero outputs with o_zero_norm set.
// The pipeline has two front stages for the squares and their sum, one stage
// per result bit of the rounding search, and one output stage. A new request
// is taken every cycle while o_stall is low.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall rises, so nothing is lost or repeated.
// Reset clears all valid bits; the data path needs no reset.
// ----------------------------------------------------------------------------
module quaternion_normalizer #(
    parameter int COMP_BITS     = 32,
    parameter int OUT_FRAC_BITS = 30
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [COMP_BITS-1:0] i_w,
    input  logic [COMP_BITS-1:0] i_x,
    input  logic [COMP_BITS-1:0] i_y,
    input  logic [COMP_BITS-1:0] i_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output qn_pkg::t_out         o_w,
    output qn_pkg::t_out         o_x,
    output qn_pkg::t_out         o_y,
    output qn_pkg::t_out         o_z,
    output logic                 o_zero_norm
);
    import qn_pkg::*;

    localparam int C    = COMP_BITS;
    localparam int F    = OUT_FRAC_BITS;
    localparam int W    = 2 * C + 2 * F + 6;
    localparam int LAST = F + 2;
    localparam int XW   = (F + 2 > OUT_BITS) ? F + 2 : OUT_BITS;

    logic                                 en;
    logic [LAST+1:0]                      r_vld;
    logic [NUM_COMP-1:0][C-1:0]           comp;
    logic [NUM_COMP-1:0][W-1:0]           front_d;
    logic [W-1:0]                         front_s;
    logic [NUM_COMP-1:0]                  front_neg;
    logic                                 front_zero;
    logic [W-1:0]                         r_s    [1:LAST];
    logic [NUM_COMP-1:0]                  r_neg  [1:LAST];
    logic                                 r_zero [1:LAST];
    logic [NUM_COMP-1:0][W-1:0]           d_st   [1:LAST];
    logic [NUM_COMP-1:0][W-1:0]           p_st   [1:LAST];
    logic [NUM_COMP-1:0][F:0]             q_st   [1:LAST];
    t_out                                 r_out  [NUM_COMP];
    logic                                 r_zero_out;

    assign en      = !(r_vld[LAST+1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAST+1];
    assign comp    = {i_z, i_y, i_x, i_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST:0], i_valid};
        end
    end

    qn_front #(.C(C), .F(F), .W(W)) u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_comp (comp),
        .o_d    (front_d),
        .o_s    (front_s),
        .o_neg  (front_neg),
        .o_zero (front_zero)
    );

    assign r_s[1]    = front_s;
    assign r_neg[1]  = front_neg;
    assign r_zero[1] = front_zero;
    assign d_st[1]   = front_d;
    assign q_st[1]   = '0;

    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            p_st[1][i] = '0 - front_s;
        end
    end

    for (genvar j = 0; j <= F; j++) begin : g_bit
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s[j+2]    <= r_s[j+1];
                r_neg[j+2]  <= r_neg[j+1];
                r_zero[j+2] <= r_zero[j+1];
            end
        end
        for (genvar i = 0; i < NUM_COMP; i++) begin : g_comp
            qn_bit #(.F(F), .W(W), .B(F - j)) u_bit (
                .i_clk (i_clk),
                .i_en  (en),
                .i_s   (r_s[j+1]),
                .i_d   (d_st[j+1][i]),
                .i_p   (p_st[j+1][i]),
                .i_q   (q_st[j+1][i]),
                .o_d   (d_st[j+2][i]),
                .o_p   (p_st[j+2][i]),
                .o_q   (q_st[j+2][i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        logic [XW-1:0] mag;
        if (en) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                mag = XW'(q_st[LAST][i]);
                if (r_zero[LAST]) begin
                    r_out[i] <= '0;
                end else if (r_neg[LAST][i]) begin
                    r_out[i] <= OUT_BITS'('0 - mag);
                end else begin
                    r_out[i] <= OUT_BITS'(mag);
                end
            end
            r_zero_out <= r_zero[LAST];
        end
    end

    assign o_w         = r_out[0];
    assign o_x         = r_out[1];
    assign o_y         = r_out[2];
    assign o_z         = r_out[3];
    assign o_zero_norm = r_zero_out;

`include "quaternion_normalizer_assert.svh"

    `QN_ASSERT_SAME(a_zero_out, i_clk, i_rst_n, o_valid && o_zero_norm, (o_w == '0) && (o_x == '0) && (o_y == '0) && (o_z == '0), "zero flag with nonzero output")
    `QN_ASSERT_SAME(a_stall_valid, i_clk, i_rst_n, o_stall, o_valid, "stall without waiting result")
    `QN_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(r_vld), "pipeline moved while stalled")

endmodule
